### rtl/bpa_pkg.sv
// shared constants, codes and types of the bitmap page allocator
`timescale 1ns / 1ps

package bpa_pkg;

   localparam int WORD_BITS  = 8;
   localparam int WORD_COUNT = 8192;
   localparam int ADDR_BITS  = 13;
   localparam int CNT_BITS   = 17;
   localparam int PAGE_BITS  = 16;

   // largest page limit the page fields can express
   localparam logic [CNT_BITS-1:0] PAGE_CAP = 17'h10000;

   localparam logic [1:0] MODE_ALLOC   = 2'd0;
   localparam logic [1:0] MODE_FREE    = 2'd1;
   localparam logic [1:0] MODE_RESERVE = 2'd2;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NO_SPACE = 2'd1;
   localparam logic [1:0] STATUS_RANGE    = 2'd2;

   typedef struct packed {
      logic                 en;
      logic [ADDR_BITS-1:0] addr;
      logic [WORD_BITS-1:0] data;
   } ram_wr_type;

   typedef struct packed {
      logic                hit;
      logic [2:0]          hit_bit;
      logic [CNT_BITS-1:0] run_out;
   } scan_result_type;

endpackage

### rtl/bitmap_page_allocator.sv
// Bitmap page allocator, first fit, one bit per page (1 = used) held in an 8192 x 8 memory.
// After reset a clearing pass writes every word to all-used, during which req_stall stays
// high (csr writes are taken as ever). One request is handled at a time, the memory read
// port setting the pace at one bitmap word (8 pages) per cycle. Refused, out-of-range,
// zero-length and unknown-mode requests go straight to the result; free and reserve read
// and write back each word touched; an allocate scans the words below the page limit and,
// if it finds its run, marks the words of that run. A result waits in the rsp register
// while rsp_stall holds it, and the next request is taken no sooner than the cycle after
// the result is loaded.
`timescale 1ns / 1ps

module bitmap_page_allocator import bpa_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_mode,
   input  logic [PAGE_BITS-1:0] req_first_page,
   input  logic [CNT_BITS-1:0]  req_run_length,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_status,
   output logic [PAGE_BITS-1:0] rsp_start_page,
   output logic [CNT_BITS-1:0]  rsp_free_count,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CNT_BITS-1:0]  csr_write_data
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_MARK,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;

   logic [ADDR_BITS:0]   cnt_ff, cnt_in;
   logic                 pend_ff, pend_in;
   logic [ADDR_BITS-1:0] data_addr_ff, data_addr_in;
   logic [CNT_BITS-1:0]  run_ff, run_in;
   logic [CNT_BITS-1:0]  need_ff, need_in;
   logic [PAGE_BITS-1:0] mark_first_ff, mark_first_in;
   logic [PAGE_BITS-1:0] mark_last_ff, mark_last_in;
   logic                 mark_set_ff, mark_set_in;
   logic [1:0]           res_status_ff, res_status_in;
   logic [PAGE_BITS-1:0] res_start_ff, res_start_in;
   logic [CNT_BITS-1:0]  free_pages_ff, free_pages_in;
   logic [CNT_BITS-1:0]  pages_in_use_ff, pages_in_use_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic [PAGE_BITS-1:0] rsp_start_ff, rsp_start_in;
   logic [CNT_BITS-1:0]  rsp_free_ff, rsp_free_in;

   ram_wr_type           ram_wr;
   logic                 ram_rd_en;
   logic [ADDR_BITS-1:0] ram_rd_addr;
   logic [WORD_BITS-1:0] ram_rd_data;
   scan_result_type      scan;

   logic [CNT_BITS-1:0]  lim;
   logic [CNT_BITS-1:0]  lim_round;
   logic [ADDR_BITS:0]   word_total;
   logic [CNT_BITS-1:0]  hit_page;
   logic [CNT_BITS-1:0]  start_page;
   logic [CNT_BITS:0]    range_end;
   logic [CNT_BITS:0]    free_sum;
   logic [CNT_BITS-1:0]  free_added;
   logic [CNT_BITS-1:0]  free_less_req;
   logic [CNT_BITS-1:0]  free_less_need;
   logic [WORD_BITS-1:0] lo_mask;
   logic [WORD_BITS-1:0] hi_mask;
   logic [WORD_BITS-1:0] mark_mask;

   function automatic logic [CNT_BITS-1:0] sat_sub(input logic [CNT_BITS-1:0] total,
                                                   input logic [CNT_BITS-1:0] amount);
      return (amount >= total) ? '0 : CNT_BITS'(total - amount);
   endfunction

   bpa_bitmap_ram u_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   bpa_word_scan u_scan (
      .word_data (ram_rd_data),
      .word_addr (data_addr_ff),
      .lim       (lim),
      .run_in    (run_ff),
      .need      (need_ff),
      .result    (scan)
   );

   assign lim        = (pages_in_use_ff > PAGE_CAP) ? PAGE_CAP : pages_in_use_ff;
   assign lim_round  = CNT_BITS'(lim + CNT_BITS'(7));
   assign word_total = lim_round[CNT_BITS-1:3];

   assign hit_page   = {1'b0, data_addr_ff, scan.hit_bit};
   assign start_page = CNT_BITS'(hit_page + CNT_BITS'(1) - need_ff);

   assign range_end      = {2'b00, req_first_page} + {1'b0, req_run_length};
   assign free_sum       = {1'b0, free_pages_ff} + {1'b0, req_run_length};
   assign free_added     = (free_sum > {1'b0, lim}) ? lim : free_sum[CNT_BITS-1:0];
   assign free_less_req  = sat_sub(free_pages_ff, req_run_length);
   assign free_less_need = sat_sub(free_pages_ff, need_ff);

   // partial words at both ends of the range
   assign lo_mask   = 8'hFF << mark_first_ff[2:0];
   assign hi_mask   = 8'hFF >> (3'd7 - mark_last_ff[2:0]);
   assign mark_mask = ((data_addr_ff == mark_first_ff[PAGE_BITS-1:3]) ? lo_mask : 8'hFF) &
                      ((data_addr_ff == mark_last_ff[PAGE_BITS-1:3]) ? hi_mask : 8'hFF);

   always_comb begin
      state_in        = state_ff;
      cnt_in          = cnt_ff;
      pend_in         = pend_ff;
      data_addr_in    = data_addr_ff;
      run_in          = run_ff;
      need_in         = need_ff;
      mark_first_in   = mark_first_ff;
      mark_last_in    = mark_last_ff;
      mark_set_in     = mark_set_ff;
      res_status_in   = res_status_ff;
      res_start_in    = res_start_ff;
      free_pages_in   = free_pages_ff;
      pages_in_use_in = pages_in_use_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_start_in    = rsp_start_ff;
      rsp_free_in     = rsp_free_ff;
      ram_wr.en       = 1'b0;
      ram_wr.addr     = data_addr_ff;
      ram_wr.data     = ram_rd_data;
      ram_rd_en       = 1'b0;
      ram_rd_addr     = cnt_ff[ADDR_BITS-1:0];

      if (csr_valid) begin
         pages_in_use_in = csr_write_data;
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = cnt_ff[ADDR_BITS-1:0];
            ram_wr.data = 8'hFF;
            cnt_in      = cnt_ff + 1'b1;
            if (cnt_ff[ADDR_BITS-1:0] == ADDR_BITS'(WORD_COUNT - 1)) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            pend_in       = 1'b0;
            res_start_in  = '0;
            res_status_in = STATUS_OK;
            if (req_valid) begin
               state_in = ST_FINISH;
               case (req_mode)
                  MODE_ALLOC: begin
                     if (req_run_length != '0) begin
                        if (free_pages_ff >= req_run_length && req_run_length <= lim) begin
                           need_in  = req_run_length;
                           run_in   = '0;
                           cnt_in   = '0;
                           state_in = ST_SCAN;
                        end else begin
                           res_status_in = STATUS_NO_SPACE;
                        end
                     end
                  end
                  MODE_FREE, MODE_RESERVE: begin
                     if (range_end > {1'b0, lim}) begin
                        res_status_in = STATUS_RANGE;
                     end else begin
                        free_pages_in = (req_mode == MODE_FREE) ? free_added : free_less_req;
                        if (req_run_length != '0) begin
                           mark_first_in = req_first_page;
                           mark_last_in  = PAGE_BITS'(range_end - 1'b1);
                           mark_set_in   = (req_mode == MODE_RESERVE);
                           cnt_in        = {1'b0, req_first_page[PAGE_BITS-1:3]};
                           state_in      = ST_MARK;
                        end
                     end
                  end
                  default: begin
                     res_status_in = STATUS_OK;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            pend_in = 1'b0;
            if (cnt_ff < word_total) begin
               ram_rd_en    = 1'b1;
               cnt_in       = cnt_ff + 1'b1;
               pend_in      = 1'b1;
               data_addr_in = cnt_ff[ADDR_BITS-1:0];
            end
            if (pend_ff) begin
               if (scan.hit) begin
                  free_pages_in = free_less_need;
                  res_start_in  = start_page[PAGE_BITS-1:0];
                  mark_first_in = start_page[PAGE_BITS-1:0];
                  mark_last_in  = hit_page[PAGE_BITS-1:0];
                  mark_set_in   = 1'b1;
                  cnt_in        = {1'b0, start_page[PAGE_BITS-1:3]};
                  pend_in       = 1'b0;
                  state_in      = ST_MARK;
               end else begin
                  run_in = scan.run_out;
               end
            end else if (cnt_ff >= word_total) begin
               res_status_in = STATUS_NO_SPACE;
               state_in      = ST_FINISH;
            end
         end
         ST_MARK: begin
            pend_in = 1'b0;
            // write back word k while word k + 1 is read
            if (pend_ff) begin
               ram_wr.en   = 1'b1;
               ram_wr.data = mark_set_ff ? (ram_rd_data | mark_mask)
                                         : (ram_rd_data & ~mark_mask);
            end
            if (cnt_ff <= {1'b0, mark_last_ff[PAGE_BITS-1:3]}) begin
               ram_rd_en    = 1'b1;
               cnt_in       = cnt_ff + 1'b1;
               pend_in      = 1'b1;
               data_addr_in = cnt_ff[ADDR_BITS-1:0];
            end else if (!pend_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_start_in  = res_start_ff;
               rsp_free_in   = free_pages_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         cnt_ff          <= '0;
         pend_ff         <= 1'b0;
         free_pages_ff   <= '0;
         pages_in_use_ff <= PAGE_CAP;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         cnt_ff          <= cnt_in;
         pend_ff         <= pend_in;
         free_pages_ff   <= free_pages_in;
         pages_in_use_ff <= pages_in_use_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      data_addr_ff  <= data_addr_in;
      run_ff        <= run_in;
      need_ff       <= need_in;
      mark_first_ff <= mark_first_in;
      mark_last_ff  <= mark_last_in;
      mark_set_ff   <= mark_set_in;
      res_status_ff <= res_status_in;
      res_start_ff  <= res_start_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_free_ff   <= rsp_free_in;
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_start_page = rsp_start_ff;
   assign rsp_free_count = rsp_free_ff;

   // free counter never passes the largest page limit
   assert property (@(posedge clock) disable iff (reset) free_pages_ff <= PAGE_CAP)
      else $error("free page counter above page cap");

   // a found run lies wholly below the page limit
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && pend_ff && scan.hit) |->
      ({1'b0, start_page} + {1'b0, need_ff} <= {1'b0, lim}))
      else $error("allocated run crosses page limit");

   // only a successful allocation reports a start page
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_OK) |-> (rsp_start_page == '0))
      else $error("start page set on failed request");

endmodule

### rtl/bpa_bitmap_ram.sv
// bitmap storage: one write port, one registered read port
`timescale 1ns / 1ps

module bpa_bitmap_ram import bpa_pkg::*; (
   input  logic                 clock,
   input  ram_wr_type           wr,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WORD_BITS-1:0] rd_data
);

   logic [WORD_BITS-1:0] mem [WORD_COUNT];
   logic [WORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/bpa_word_scan.sv
// free-run tracking over one bitmap word, finds the lowest page that completes a run
`timescale 1ns / 1ps

module bpa_word_scan import bpa_pkg::*; (
   input  logic [WORD_BITS-1:0] word_data,
   input  logic [ADDR_BITS-1:0] word_addr,
   input  logic [CNT_BITS-1:0]  lim,
   input  logic [CNT_BITS-1:0]  run_in,
   input  logic [CNT_BITS-1:0]  need,
   output scan_result_type      result
);

   logic [WORD_BITS-1:0] used;
   logic [CNT_BITS-1:0]  run_at [WORD_BITS];

   always_comb begin
      for (int i = 0; i < WORD_BITS; i++) begin
         // pages at or above the limit count as used
         used[i] = word_data[i] | ({1'b0, word_addr, 3'(i)} >= lim);
      end
   end

   always_comb begin
      for (int i = 0; i < WORD_BITS; i++) begin
         run_at[i] = CNT_BITS'(run_in + CNT_BITS'(i + 1));
         // highest used page at or below i ends the carried run
         for (int j = 0; j <= i; j++) begin
            if (used[j]) begin
               run_at[i] = CNT_BITS'(i - j);
            end
         end
      end
   end

   always_comb begin
      result.hit     = 1'b0;
      result.hit_bit = 3'd0;
      result.run_out = run_at[WORD_BITS-1];
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (run_at[i] >= need) begin
            result.hit     = 1'b1;
            result.hit_bit = 3'(i);
         end
      end
   end

endmodule
